// ----- rtl/u16u8_pkg.sv -----
// Package with shared types, constants and the UTF-8 encoding function.
`default_nettype none
package u16u8_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxBytes   = 6;

  localparam logic [5:0]  HiPrefix  = 6'b110110;
  localparam logic [5:0]  LoPrefix  = 6'b110111;
  localparam logic [20:0] SuppBase  = 21'h10000;
  localparam logic [20:0] Lim1Byte  = 21'h80;
  localparam logic [20:0] Lim2Byte  = 21'h800;

  typedef logic [20:0] cp_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } enc_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;
    logic                     fin;
  } entry_t;

  function automatic enc_t encode_cp(input cp_t cp);
    enc_t r;
    r.bytes = '0;
    if (cp < Lim1Byte) begin
      r.bytes[0] = {1'b0, cp[6:0]};
      r.len      = 3'd1;
    end else if (cp < Lim2Byte) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.len      = 3'd2;
    end else if (cp < SuppBase) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.len      = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.len      = 3'd4;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/u16u8_front.sv -----
// Front end: accepts code units, pairs surrogates and builds byte groups.
`default_nettype none
module u16u8_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [15:0]       code_unit_i,
  input  wire logic              final_unit_i,
  output logic                   push_o,
  output u16u8_pkg::entry_t      entry_o,
  input  wire logic              q_ready_i
);
  import u16u8_pkg::*;

  logic       pend_valid_q, pend_valid_d;
  logic [9:0] pend_high_q, pend_high_d;
  logic       is_hi, is_lo, accept;
  enc_t       cur_enc, held_enc, pair_enc;
  entry_t     entry;

  assign is_hi   = code_unit_i[15:10] == HiPrefix;
  assign is_lo   = code_unit_i[15:10] == LoPrefix;
  assign accept  = in_valid_i && q_ready_i;

  assign cur_enc  = encode_cp({5'd0, code_unit_i});
  assign held_enc = encode_cp({5'd0, HiPrefix, pend_high_q});
  assign pair_enc = encode_cp(SuppBase + {1'b0, pend_high_q, code_unit_i[9:0]});

  always_comb begin
    entry        = '0;
    entry.fin    = final_unit_i;
    pend_valid_d = pend_valid_q;
    pend_high_d  = pend_high_q;
    if (pend_valid_q && is_lo) begin
      for (int k = 0; k < 4; k++) entry.bytes[k] = pair_enc.bytes[k];
      entry.count  = 3'd4;
      pend_valid_d = 1'b0;
    end else begin
      pend_valid_d = 1'b0;
      if (pend_valid_q) begin
        for (int k = 0; k < 3; k++) entry.bytes[k] = held_enc.bytes[k];
        entry.count = 3'd3;
      end
      if (is_hi && !final_unit_i) begin
        pend_valid_d = 1'b1;
        pend_high_d  = code_unit_i[9:0];
      end else if (pend_valid_q) begin
        for (int k = 0; k < 3; k++) entry.bytes[k+3] = cur_enc.bytes[k];
        entry.count = 3'd3 + cur_enc.len;
      end else begin
        for (int k = 0; k < 3; k++) entry.bytes[k] = cur_enc.bytes[k];
        entry.count = cur_enc.len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_high_q  <= '0;
    end else if (accept) begin
      pend_valid_q <= pend_valid_d;
      pend_high_q  <= pend_high_d;
    end
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = accept && (entry.count != 3'd0);
  assign entry_o    = entry;

endmodule
`default_nettype wire

// ----- rtl/u16u8_queue.sv -----
// Small queue of byte groups between the front and back ends.
`default_nettype none
module u16u8_queue #(
  parameter int unsigned Depth = u16u8_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire u16u8_pkg::entry_t entry_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output u16u8_pkg::entry_t      entry_o,
  input  wire logic              pop_i
);
  import u16u8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ready_o = cnt_q != CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/u16u8_back.sv -----
// Back end: serializes each byte group onto the output, one byte per cycle while out_ready_i is high.
`default_nettype none
module u16u8_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire u16u8_pkg::entry_t q_entry_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   run_last_o,
  output logic                   string_done_o
);
  import u16u8_pkg::*;

  entry_t     entry_q;
  logic       valid_q;
  logic [2:0] idx_q;
  logic       last, done_byte;

  assign last      = idx_q == (entry_q.count - 3'd1);
  assign done_byte = valid_q && out_ready_i;
  assign pop_o     = q_valid_i && (!valid_q || (done_byte && last));

  always_ff @(posedge clk_i) begin
    if (pop_o) entry_q <= q_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (done_byte) begin
      if (last) begin
        valid_q <= 1'b0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = entry_q.bytes[idx_q];
  assign run_last_o    = last;
  assign string_done_o = last && entry_q.fin;

endmodule
`default_nettype wire

// ----- rtl/utf16_to_utf8_encoder_top.sv -----
// Top level of the UTF-16 to UTF-8 transcoder.
// Path: a unit's bytes are queued, then loaded into the back end's group register.
// Throughput: one output byte per cycle while out_ready_i is high, set by the back end;
// a unit gives 1 to 6 bytes (up to 4 for well-formed text), a held high surrogate none.
// Reset: asynchronous, active low; clears the held surrogate, the queue and the output.
`default_nettype none
module utf16_to_utf8_encoder_top #(
  parameter int unsigned QueueDepth = u16u8_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        final_unit_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             string_done_o
);
  import u16u8_pkg::*;

  entry_t push_entry, head_entry;
  logic   push, q_ready, q_valid, pop;

  u16u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .final_unit_i (final_unit_i),
    .push_o       (push),
    .entry_o      (push_entry),
    .q_ready_i    (q_ready)
  );

  u16u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .pop_i   (pop)
  );

  u16u8_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the UTF-16 to UTF-8 transcoder, with directed and random strings.
module testbench;

  localparam int          ItemTarget  = 460;
  localparam int          IdleLimit   = 2000;
  localparam int          DrainCycles = 10;
  localparam int          ReportCap   = 40;
  localparam int          NumDirected = 25;
  localparam logic [3:0]  UsePredictor = 4'hF;

  localparam logic [15:0] HiFirst = 16'hD800;
  localparam logic [15:0] HiLast  = 16'hDBFF;
  localparam logic [15:0] LoFirst = 16'hDC00;
  localparam logic [15:0] LoLast  = 16'hDFFF;
  localparam logic [20:0] SuppFirst    = 21'h10000;
  localparam logic [20:0] OneByteLimit = 21'h80;
  localparam logic [20:0] TwoByteLimit = 21'h800;

  typedef struct packed {
    logic [7:0] data;
    logic       last_of_unit;
    logic       end_of_string;
  } utf8_beat_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        fin;
    logic [3:0]  count;
    logic [47:0] bytes;
  } unit_row_t;

  // A count of UsePredictor means the bytes come from the transcoder model below.
  localparam unit_row_t DirRows [NumDirected] = '{
    '{16'h0041, 1'b0, 4'd1, 48'h41},
    '{16'h0000, 1'b0, 4'd1, 48'h00},
    '{16'h007F, 1'b0, 4'd1, 48'h7F},
    '{16'h0080, 1'b0, 4'd2, 48'hC280},
    '{16'h07FF, 1'b0, 4'd2, 48'hDFBF},
    '{16'h0800, 1'b0, 4'd3, 48'hE0A080},
    '{16'hFFFF, 1'b0, 4'd3, 48'hEFBFBF},
    '{16'hD800, 1'b0, 4'd0, 48'h0},
    '{16'hDC00, 1'b0, 4'd4, 48'hF0908080},
    '{16'hDBFF, 1'b0, 4'd0, 48'h0},
    '{16'hDFFF, 1'b1, 4'd4, 48'hF48FBFBF},
    '{16'hDC00, 1'b0, 4'd3, 48'hEDB080},
    '{16'hDFFF, 1'b0, 4'd3, 48'hEDBFBF},
    '{16'hD800, 1'b0, 4'd0, 48'h0},
    '{16'h0041, 1'b0, 4'd4, 48'hEDA08041},
    '{16'hDBFF, 1'b0, 4'd0, 48'h0},
    '{16'hD800, 1'b0, 4'd3, 48'hEDAFBF},
    '{16'hFFFF, 1'b0, 4'd6, 48'hEDA080EFBFBF},
    '{16'hDBFF, 1'b1, 4'd3, 48'hEDAFBF},
    '{16'hD800, 1'b0, 4'd0, 48'h0},
    '{16'hDBFF, 1'b1, UsePredictor, 48'h0},
    '{16'h5555, 1'b0, UsePredictor, 48'h0},
    '{16'hAAAA, 1'b1, UsePredictor, 48'h0},
    '{16'hD7FF, 1'b0, UsePredictor, 48'h0},
    '{16'hE000, 1'b1, UsePredictor, 48'h0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] code_unit_i = 16'h0000;
  logic        final_unit_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        string_done_o;

  utf8_beat_t  expected_utf8 [$];
  logic [7:0]  unit_utf8 [$];
  logic [9:0]  held_bits = '0;
  logic        held_valid = 1'b0;
  int          units_sent = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  logic        calm;
  utf8_beat_t  want;

  assign calm = (units_sent >= 150 && units_sent < 200) || units_sent >= ItemTarget - 70;

  utf16_to_utf8_encoder_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_unit_i   (code_unit_i),
    .final_unit_i  (final_unit_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void append_code_point(input logic [20:0] cp);
    if (cp < OneByteLimit) begin
      unit_utf8.push_back(cp[7:0]);
    end else if (cp < TwoByteLimit) begin
      unit_utf8.push_back({3'b110, cp[10:6]});
      unit_utf8.push_back({2'b10, cp[5:0]});
    end else if (cp < SuppFirst) begin
      unit_utf8.push_back({4'b1110, cp[15:12]});
      unit_utf8.push_back({2'b10, cp[11:6]});
      unit_utf8.push_back({2'b10, cp[5:0]});
    end else begin
      unit_utf8.push_back({5'b11110, cp[20:18]});
      unit_utf8.push_back({2'b10, cp[17:12]});
      unit_utf8.push_back({2'b10, cp[11:6]});
      unit_utf8.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // Computes the bytes that one accepted code unit completes and updates the held surrogate.
  function automatic void transcode_unit(input logic [15:0] unit, input logic fin);
    logic is_hi;
    logic is_lo;
    is_hi = unit >= HiFirst && unit <= HiLast;
    is_lo = unit >= LoFirst && unit <= LoLast;
    unit_utf8.delete();
    if (held_valid) begin
      held_valid = 1'b0;
      if (is_lo) begin
        append_code_point(SuppFirst + {1'b0, held_bits, unit[9:0]});
        return;
      end
      append_code_point({5'b0, HiFirst} + {11'b0, held_bits});
    end
    if (is_hi && !fin) begin
      held_bits  = unit[9:0];
      held_valid = 1'b1;
    end else begin
      append_code_point({5'b0, unit});
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] exp_val,
                                 input logic [7:0] got_val);
    if (mismatches < ReportCap) begin
      $display("ERROR at %0t: %s, expected %h, got %h", $time, what, exp_val, got_val);
    end
    mismatches++;
  endtask

  task automatic send_unit(input logic [15:0] unit, input logic fin, input logic [3:0] typed_n,
                           input logic [47:0] typed_bytes);
    int k;
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    code_unit_i  <= unit;
    final_unit_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    units_sent++;
    transcode_unit(unit, fin);
    if (typed_n != UsePredictor) begin
      unit_utf8.delete();
      for (k = int'(typed_n) - 1; k >= 0; k--) unit_utf8.push_back(typed_bytes[8*k +: 8]);
    end
    n = unit_utf8.size();
    for (k = 0; k < n; k++) begin
      expected_utf8.push_back(utf8_beat_t'{unit_utf8[k], k == n - 1, k == n - 1 && fin});
    end
  endtask

  task automatic send_random_string();
    logic [15:0] units [$];
    int len;
    int k;
    len = $urandom_range(1, 8);
    while (units.size() < len) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: units.push_back(16'($urandom_range(16'h0001, 16'h007F)));
        5, 6, 7, 8:    units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
        9, 10, 11, 12: begin
          units.push_back(16'($urandom_range(16'h0800, 16'hF7FF)));
          if (units[$] >= HiFirst) units[$] = units[$] + 16'h0800;
        end
        13, 14, 15, 16: begin
          units.push_back(16'($urandom_range(HiFirst, HiLast)));
          units.push_back(16'($urandom_range(LoFirst, LoLast)));
        end
        17:      units.push_back(16'($urandom_range(HiFirst, HiLast)));
        18:      units.push_back(16'($urandom_range(LoFirst, LoLast)));
        default: units.push_back(16'($urandom_range(0, 16'hFFFF)));
      endcase
    end
    for (k = 0; k < units.size(); k++) begin
      send_unit(units[k], k == units.size() - 1, UsePredictor, 48'h0);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left = stall_left - 1;
    else if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
    out_ready_i <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_utf8.size() == 0) begin
        report_mismatch("byte with no expectation", 8'h00, out_byte_o);
      end else begin
        want = expected_utf8.pop_front();
        if (out_byte_o !== want.data) report_mismatch("out_byte", want.data, out_byte_o);
        if (run_last_o !== want.last_of_unit) begin
          report_mismatch("run_last", {7'b0, want.last_of_unit}, {7'b0, run_last_o});
        end
        if (string_done_o !== want.end_of_string) begin
          report_mismatch("string_done", {7'b0, want.end_of_string}, {7'b0, string_done_o});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (r = 0; r < NumDirected; r++) begin
      send_unit(DirRows[r].unit, DirRows[r].fin, DirRows[r].count, DirRows[r].bytes);
    end
    while (units_sent < ItemTarget) send_random_string();
    in_valid_i <= 1'b0;
    while (expected_utf8.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
